/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the sphere grid cell enumerator unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGCE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgce: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SGCE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgce: next-cycle check failed");

`endif

/* sv/sgce_pkg.sv */
// ----------------------------------------------------------------------------
// sgce_pkg
// types and constants of the sphere grid cell enumerator
// ----------------------------------------------------------------------------
package sgce_pkg;

   localparam int SPAN             = 4;
   localparam int CNT_W            = (SPAN > 1) ? $clog2(SPAN) : 1;
   localparam int POS_W            = 24;
   localparam int RAD_W            = 23;
   localparam int IDX_W            = 16;
   localparam int CS_W             = 4;
   localparam int SHIFT_W          = 5;
   localparam int FRAC_BITS        = 8;
   localparam int CELL_SHIFT_MAX   = 10;
   localparam int CELL_SHIFT_RESET = 4;
   // coordinates of bounds and cell corners, with headroom for one edge
   localparam int COORD_W          = 27;
   // per-axis distance never exceeds the radius
   localparam int D_W              = RAD_W;
   localparam int SQ_W             = 2 * D_W;
   localparam int SUM_W            = SQ_W + 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [CNT_W-1:0]   cnt_type;
   typedef logic        [IDX_W-1:0]   idx_type;

   typedef struct packed {
      logic load;
      logic bound;
      logic range_calc;
      logic issue;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic walk_last;
      logic pipe_busy;
      logic pend_valid;
      logic out_blocked;
   } status_type;

endpackage

/* sv/sgce_ctrl.sv */
// ----------------------------------------------------------------------------
// sgce_ctrl
// sequencer: setup, candidate walk, drain and final flush of one sphere
// ----------------------------------------------------------------------------
module sgce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sgce_pkg::status_type status,
   output sgce_pkg::cmd_type    cmd
);
   import sgce_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BOUND = 6'b000010,
      ST_RANGE = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.bound      = (state_ff == ST_BOUND);
      cmd.range_calc = (state_ff == ST_RANGE);
      cmd.issue      = (state_ff == ST_WALK) && !status.out_blocked;
      cmd.flush      = (state_ff == ST_FLUSH) && status.pend_valid && !status.out_blocked;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_BOUND;
         end
         ST_BOUND: state_in = ST_RANGE;
         ST_RANGE: state_in = ST_WALK;
         ST_WALK: begin
            if (cmd.issue && status.walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!status.pend_valid || cmd.flush) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/sgce_datapath.sv */
// ----------------------------------------------------------------------------
// sgce_datapath
// bounds, cell walker, distance pipeline, one-deep hold and result register
// ----------------------------------------------------------------------------
module sgce_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic        [sgce_pkg::CS_W-1:0]       csr_write_data,
   input  logic signed [sgce_pkg::POS_W-1:0]      req_center_x,
   input  logic signed [sgce_pkg::POS_W-1:0]      req_center_y,
   input  logic signed [sgce_pkg::POS_W-1:0]      req_center_z,
   input  logic        [sgce_pkg::RAD_W-1:0]      req_radius,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic signed [sgce_pkg::IDX_W-1:0]      rsp_cell_x,
   output logic signed [sgce_pkg::IDX_W-1:0]      rsp_cell_y,
   output logic signed [sgce_pkg::IDX_W-1:0]      rsp_cell_z,
   output logic                                   rsp_last,
   output logic                                   rsp_clipped,
   input  sgce_pkg::cmd_type                      cmd,
   output sgce_pkg::status_type                   status
);
   import sgce_pkg::*;

   // squared-distance operand: distance from c to the closed cell [lo, lo + cell_len]
   function automatic logic [D_W-1:0] axis_dist(coord_type c, coord_type lo,
                                                coord_type cell_len);
      coord_type hi;
      coord_type d;
      hi = lo + cell_len;
      if (c < lo)      d = lo - c;
      else if (c > hi) d = c - hi;
      else             d = '0;
      return d[D_W-1:0];
   endfunction

   logic [CS_W-1:0]    cell_shift_ff;
   logic [SHIFT_W-1:0] shift_ff;
   coord_type          c_ff      [3];
   logic [RAD_W-1:0]   r_ff;
   logic [SQ_W-1:0]    r2_ff;
   coord_type          edge_ff;
   coord_type          lo_bnd_ff [3];
   coord_type          hi_bnd_ff [3];
   coord_type          base_ff   [3];
   idx_type            base_idx_ff [3];
   cnt_type            max_ff    [3];
   logic               clip_ff;

   // walker
   coord_type          pos_ff [3], pos_in [3];
   idx_type            idx_ff [3], idx_in [3];
   cnt_type            cnt_ff [3], cnt_in [3];

   // distance and square stages
   logic               b_valid_ff, b_valid_in;
   logic [D_W-1:0]     d_b_ff   [3];
   idx_type            idx_b_ff [3];
   logic               c_valid_ff, c_valid_in;
   logic [SQ_W-1:0]    sq_c_ff  [3];
   idx_type            idx_c_ff [3];

   // held hit, released once the next hit or the end of the walk is known
   logic               pend_valid_ff, pend_valid_in;
   idx_type            pend_idx_ff [3];

   logic               rsp_valid_ff, rsp_valid_in;
   idx_type            rsp_idx_ff [3];
   logic               rsp_last_ff;
   logic               rsp_clipped_ff;

   logic               adv;
   logic               hit;
   logic [SUM_W-1:0]   dist_sum;
   logic               move_pend;

   assign status.out_blocked = rsp_valid_ff && rsp_stall;
   assign adv                = !status.out_blocked;
   assign status.pipe_busy   = b_valid_ff || c_valid_ff;
   assign status.pend_valid  = pend_valid_ff;
   assign status.walk_last   = (cnt_ff[0] == max_ff[0]) && (cnt_ff[1] == max_ff[1]) &&
                               (cnt_ff[2] == max_ff[2]);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_shift_ff <= CS_W'(CELL_SHIFT_RESET);
      end else if (csr_write_en) begin
         cell_shift_ff <= csr_write_data;
      end
   end

   // setup: latch sphere, then bounds and r squared, then index range
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_ff[0] <= COORD_W'(req_center_x);
         c_ff[1] <= COORD_W'(req_center_y);
         c_ff[2] <= COORD_W'(req_center_z);
         r_ff    <= req_radius;
         if (cell_shift_ff > CS_W'(CELL_SHIFT_MAX)) begin
            shift_ff <= SHIFT_W'(CELL_SHIFT_MAX + FRAC_BITS);
         end else begin
            shift_ff <= SHIFT_W'(cell_shift_ff) + SHIFT_W'(FRAC_BITS);
         end
      end
      if (cmd.bound) begin
         r2_ff   <= SQ_W'(r_ff) * SQ_W'(r_ff);
         edge_ff <= coord_type'(1) << shift_ff;
         for (int i = 0; i < 3; i++) begin
            lo_bnd_ff[i] <= c_ff[i] - $signed(COORD_W'(r_ff));
            hi_bnd_ff[i] <= c_ff[i] + $signed(COORD_W'(r_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      coord_type lo_idx;
      coord_type hi_idx;
      coord_type diff;
      logic      clip_any;
      if (cmd.range_calc) begin
         clip_any = 1'b0;
         for (int i = 0; i < 3; i++) begin
            lo_idx = lo_bnd_ff[i] >>> shift_ff;
            hi_idx = hi_bnd_ff[i] >>> shift_ff;
            diff   = hi_idx - lo_idx;
            if (diff > $signed(COORD_W'(SPAN - 1))) begin
               max_ff[i] <= CNT_W'(SPAN - 1);
               clip_any  = 1'b1;
            end else begin
               max_ff[i] <= diff[CNT_W-1:0];
            end
            base_ff[i]     <= lo_bnd_ff[i] & ~(edge_ff - coord_type'(1));
            base_idx_ff[i] <= lo_idx[IDX_W-1:0];
         end
         clip_ff <= clip_any;
      end
   end

   // walker: z innermost, then y, then x
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
         idx_in[i] = idx_ff[i];
         cnt_in[i] = cnt_ff[i];
      end
      if (cmd.range_calc) begin
         for (int i = 0; i < 3; i++) begin
            pos_in[i] = lo_bnd_ff[i] & ~(edge_ff - coord_type'(1));
            idx_in[i] = IDX_W'(lo_bnd_ff[i] >>> shift_ff);
            cnt_in[i] = '0;
         end
      end else if (cmd.issue) begin
         if (cnt_ff[2] != max_ff[2]) begin
            cnt_in[2] = cnt_ff[2] + CNT_W'(1);
            pos_in[2] = pos_ff[2] + edge_ff;
            idx_in[2] = idx_ff[2] + IDX_W'(1);
         end else begin
            cnt_in[2] = '0;
            pos_in[2] = base_ff[2];
            idx_in[2] = base_idx_ff[2];
            if (cnt_ff[1] != max_ff[1]) begin
               cnt_in[1] = cnt_ff[1] + CNT_W'(1);
               pos_in[1] = pos_ff[1] + edge_ff;
               idx_in[1] = idx_ff[1] + IDX_W'(1);
            end else begin
               cnt_in[1] = '0;
               pos_in[1] = base_ff[1];
               idx_in[1] = base_idx_ff[1];
               cnt_in[0] = cnt_ff[0] + CNT_W'(1);
               pos_in[0] = pos_ff[0] + edge_ff;
               idx_in[0] = idx_ff[0] + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pos_ff[i] <= pos_in[i];
         idx_ff[i] <= idx_in[i];
         cnt_ff[i] <= cnt_in[i];
      end
   end

   // distance stage and square stage, frozen while the result side is blocked
   assign b_valid_in = adv ? cmd.issue  : b_valid_ff;
   assign c_valid_in = adv ? b_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d_b_ff[i]   <= axis_dist(c_ff[i], pos_ff[i], edge_ff);
            idx_b_ff[i] <= idx_ff[i];
            sq_c_ff[i]  <= SQ_W'(d_b_ff[i]) * SQ_W'(d_b_ff[i]);
            idx_c_ff[i] <= idx_b_ff[i];
         end
      end
   end

   // compare and hold
   assign dist_sum  = SUM_W'(sq_c_ff[0]) + SUM_W'(sq_c_ff[1]) + SUM_W'(sq_c_ff[2]);
   assign hit       = adv && c_valid_ff && (dist_sum <= SUM_W'(r2_ff));
   assign move_pend = hit && pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (hit)            pend_valid_in = 1'b1;
      else if (cmd.flush) pend_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         for (int i = 0; i < 3; i++) pend_idx_ff[i] <= idx_c_ff[i];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.flush || move_pend) rsp_valid_in = 1'b1;
      else if (!rsp_stall)        rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.flush || move_pend) begin
         for (int i = 0; i < 3; i++) rsp_idx_ff[i] <= pend_idx_ff[i];
         rsp_last_ff    <= cmd.flush;
         rsp_clipped_ff <= clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         b_valid_ff    <= b_valid_in;
         c_valid_ff    <= c_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_cell_x  = rsp_idx_ff[0];
   assign rsp_cell_y  = rsp_idx_ff[1];
   assign rsp_cell_z  = rsp_idx_ff[2];
   assign rsp_last    = rsp_last_ff;
   assign rsp_clipped = rsp_clipped_ff;

endmodule

/* sv/sphere_grid_cell_enumerator_unit.sv */
// ----------------------------------------------------------------------------
// sphere_grid_cell_enumerator_unit
// lists the grid cells that a fixed-point sphere overlaps
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | transaction
//  --------+-----------+-------------------+----------------------------------
//  req     | in        | req_valid/stall   | one sphere, centre and radius
//  rsp     | out       | rsp_valid/stall   | one overlapped cell index
//  csr     | in        | csr_write_en      | cell_shift, no read-back
//
// before the next sphere can be taken, one passes the setup states ST_BOUND and
// ST_RANGE, a walk of its n candidate cells (up to 64) at one per cycle unless a stalled
// result blocks it, two pipeline stages, a drain check and the flush of the held cell
// reset is synchronous and active high; cell_shift returns to 4
// a stalled result freezes the walker and the distance pipeline; the request side
// stays stalled until the last cell, if any, is in the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sphere_grid_cell_enumerator_unit (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_en,
   input  logic        [sgce_pkg::CS_W-1:0]   csr_write_data,
   // spheres in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [sgce_pkg::POS_W-1:0]  req_center_x,
   input  logic signed [sgce_pkg::POS_W-1:0]  req_center_y,
   input  logic signed [sgce_pkg::POS_W-1:0]  req_center_z,
   input  logic        [sgce_pkg::RAD_W-1:0]  req_radius,
   // cells out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sgce_pkg::IDX_W-1:0]  rsp_cell_x,
   output logic signed [sgce_pkg::IDX_W-1:0]  rsp_cell_y,
   output logic signed [sgce_pkg::IDX_W-1:0]  rsp_cell_z,
   output logic                               rsp_last,
   output logic                               rsp_clipped
);
   import sgce_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing of setup, walk, drain and flush
   sgce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, walker and result hold
   sgce_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_center_z   (req_center_z),
      .req_radius     (req_radius),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .rsp_cell_z     (rsp_cell_z),
      .rsp_last       (rsp_last),
      .rsp_clipped    (rsp_clipped),
      .cmd            (cmd),
      .status         (status)
   );

   // a sphere keeps the request side closed on the cycle after it is taken
   `SGCE_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // nothing is left held back once the block is idle again
   `SGCE_ASSERT_IMP(a_idle_no_pending, clock, reset, !req_stall, !status.pend_valid)
   // the walker never moves while a result waits on a stalled consumer
   `SGCE_ASSERT_IMP(a_no_issue_blocked, clock, reset, cmd.issue, !status.out_blocked)
   // the final flush presents a result marked last
   `SGCE_ASSERT_NXT(a_flush_marks_last, clock, reset, cmd.flush, rsp_valid && rsp_last)

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sphere grid cell enumerator unit
//  spheres come first from a short directed table and then at random over
//  several cell sizes; every cell transaction is compared field by field with
//  the cell typed into a pinned row or an in-bench enumeration of the cells each
//  sphere overlaps, while the request side idles and the result side stalls at random
// ----------------------------------------------------------------------------
module testbench;
   import sgce_pkg::*;

   // cycles left after the last expected cell, covering a sphere that
   // yields nothing after a walk of up to 64 candidate cells
   localparam int SETTLE_CYCLES    = 100;
   localparam int N_DIRECTED       = 20;
   localparam int N_PHASES         = 4;
   localparam int RANDOM_PER_PHASE = 28;

   // one sphere; pinned rows carry their single expected cell typed in
   typedef struct packed {
      logic        [CS_W-1:0]  shift;
      logic signed [POS_W-1:0] cx;
      logic signed [POS_W-1:0] cy;
      logic signed [POS_W-1:0] cz;
      logic        [RAD_W-1:0] radius;
      logic                    pinned;
      logic signed [IDX_W-1:0] px;
      logic signed [IDX_W-1:0] py;
      logic signed [IDX_W-1:0] pz;
   } sphere_row_type;

   typedef struct packed {
      logic signed [IDX_W-1:0] x;
      logic signed [IDX_W-1:0] y;
      logic signed [IDX_W-1:0] z;
      logic                    last;
      logic                    clipped;
   } cell_hit_type;

   // grouped by cell_shift, so the register is rewritten only between groups
   localparam sphere_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // reset value of cell_shift: 16-unit cells
      '{4, 0, 0, 0, 0, 1, 0, 0, 0},                      // zero radius at origin
      '{4, -1, -1, -1, 0, 1, -1, -1, -1},                // just below zero
      '{4, 4096, 0, -4096, 0, 1, 1, 0, -1},              // centre on a boundary
      '{4, 8388607, 8388607, 8388607, 0, 1, 2047, 2047, 2047},
      '{4, -8388608, -8388608, -8388608, 0, 1, -2048, -2048, -2048},
      '{4, 2048, 2048, 2048, 1024, 1, 0, 0, 0},          // wholly inside one cell
      '{4, 4096, 4096, 4096, 256, 0, 0, 0, 0},           // corner of eight cells
      '{4, 0, 0, 0, 8388607, 0, 0, 0, 0},                // largest radius, clipped
      '{4, 2048, -2048, 6144, 6000, 0, 0, 0, 0},
      // one-unit cells
      '{0, 0, 0, 0, 2560, 0, 0, 0, 0},                   // clipped, no cell found
      '{0, -8388608, 0, 0, 1, 0, 0, 0, 0},               // index wraps past 16 bits
      '{0, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 0},
      '{0, 128, 128, 128, 0, 1, 0, 0, 0},
      '{0, 8388607, -8388608, 128, 0, 1, 32767, -32768, 0},
      // largest cells
      '{10, 0, 0, 0, 8388607, 0, 0, 0, 0},
      '{10, 8388607, -8388608, 0, 0, 1, 31, -32, 0},
      '{10, 131072, 131072, 131072, 131072, 0, 0, 0, 0},
      // out-of-range shifts behave as the largest
      '{15, 8388607, -8388608, 0, 0, 1, 31, -32, 0},
      '{15, 262144, 0, 0, 262144, 0, 0, 0, 0},
      '{11, -1, 0, 1, 0, 1, -1, 0, 0}
   };

   logic                    clock;
   logic                    reset;
   logic                    csr_write_en;
   logic        [CS_W-1:0]  csr_write_data;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [POS_W-1:0] req_center_x;
   logic signed [POS_W-1:0] req_center_y;
   logic signed [POS_W-1:0] req_center_z;
   logic        [RAD_W-1:0] req_radius;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [IDX_W-1:0] rsp_cell_x;
   logic signed [IDX_W-1:0] rsp_cell_y;
   logic signed [IDX_W-1:0] rsp_cell_z;
   logic                    rsp_last;
   logic                    rsp_clipped;

   // bench copy of the register and the cells still owed by the unit
   logic [CS_W-1:0] cell_shift_now;
   cell_hit_type    expected_cells [$];
   // no idling on either side while set
   logic            calm;

   int unsigned errors;
   int unsigned spheres_sent;
   int unsigned cells_checked;
   int unsigned empty_spheres;

   sphere_grid_cell_enumerator_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_center_z   (req_center_z),
      .req_radius     (req_radius),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .rsp_cell_z     (rsp_cell_z),
      .rsp_last       (rsp_last),
      .rsp_clipped    (rsp_clipped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // squared gap between a coordinate and the closed span [lo_edge, lo_edge + edge_len]
   function automatic longint axis_gap_sq(input longint c, input longint lo_edge,
                                          input longint edge_len);
      longint gap;
      gap = 0;
      if (c < lo_edge) begin
         gap = lo_edge - c;
      end else if (c > lo_edge + edge_len) begin
         gap = c - lo_edge - edge_len;
      end
      return gap * gap;
   endfunction

   // queues every overlapped cell up to SPAN per axis, x outermost and z innermost,
   // and returns how many there are
   function automatic int overlapped_cells(input logic [CS_W-1:0] shift_reg,
                                           input logic signed [POS_W-1:0] cx,
                                           input logic signed [POS_W-1:0] cy,
                                           input logic signed [POS_W-1:0] cz,
                                           input logic [RAD_W-1:0] radius);
      longint       ctr [3];
      longint       lo [3];
      longint       cnt [3];
      longint       r;
      longint       edge_len;
      longint       ix, iy, iz;
      int           s, a, i, j, k, n;
      bit           clip;
      bit           have_pending;
      cell_hit_type pending;
      s = ((shift_reg > CELL_SHIFT_MAX) ? CELL_SHIFT_MAX : int'(shift_reg)) + FRAC_BITS;
      edge_len = longint'(1) << s;
      r = longint'(radius);
      ctr[0] = longint'(cx);
      ctr[1] = longint'(cy);
      ctr[2] = longint'(cz);
      clip = 1'b0;
      n = 0;
      have_pending = 1'b0;
      pending = '0;
      // floor-aligned bounds; arithmetic shift floors negative values too
      for (a = 0; a < 3; a++) begin
         lo[a]  = (ctr[a] - r) >>> s;
         cnt[a] = ((ctr[a] + r) >>> s) - lo[a] + 1;
         if (cnt[a] > SPAN) begin
            cnt[a] = SPAN;
            clip   = 1'b1;
         end
      end
      for (i = 0; i < cnt[0]; i++) begin
         for (j = 0; j < cnt[1]; j++) begin
            for (k = 0; k < cnt[2]; k++) begin
               ix = lo[0] + i;
               iy = lo[1] + j;
               iz = lo[2] + k;
               if (axis_gap_sq(ctr[0], ix * edge_len, edge_len)
                   + axis_gap_sq(ctr[1], iy * edge_len, edge_len)
                   + axis_gap_sq(ctr[2], iz * edge_len, edge_len) <= r * r) begin
                  if (have_pending) begin
                     expected_cells.insert(expected_cells.size(), pending);
                  end
                  // indices wrap to 16 bits
                  pending.x       = ix[IDX_W-1:0];
                  pending.y       = iy[IDX_W-1:0];
                  pending.z       = iz[IDX_W-1:0];
                  pending.last    = 1'b0;
                  pending.clipped = clip;
                  have_pending    = 1'b1;
                  n++;
               end
            end
         end
      end
      if (have_pending) begin
         pending.last = 1'b1;
         expected_cells.insert(expected_cells.size(), pending);
      end
      return n;
   endfunction

   // mostly spheres of up to one or two cells in radius, some hugging cell boundaries,
   // a few zero radii and a few fully random ones
   function automatic sphere_row_type random_sphere(input logic [CS_W-1:0] shift_reg);
      sphere_row_type          sph;
      logic signed [POS_W-1:0] ctr [3];
      int unsigned             edge_len;
      int unsigned             pick;
      int                      a;
      edge_len = 32'd1 << (((shift_reg > CELL_SHIFT_MAX) ? CELL_SHIFT_MAX
                                                         : int'(shift_reg)) + FRAC_BITS);
      pick = $urandom_range(0, 9);
      for (a = 0; a < 3; a++) begin
         ctr[a] = POS_W'($urandom());
         if (pick >= 1 && pick <= 3) begin
            ctr[a] = (ctr[a] & ~POS_W'(edge_len - 1)) + POS_W'($urandom_range(0, 16))
                     - POS_W'(8);
         end
      end
      sph       = '0;
      sph.shift = shift_reg;
      sph.cx    = ctr[0];
      sph.cy    = ctr[1];
      sph.cz    = ctr[2];
      case (pick)
         0: begin
            sph.radius = RAD_W'($urandom());
         end
         1, 2, 3: begin
            sph.radius = RAD_W'($urandom_range(0, edge_len));
         end
         9: begin
            sph.radius = '0;
         end
         default: begin
            sph.radius = RAD_W'($urandom_range(0, 2 * edge_len));
         end
      endcase
      return sph;
   endfunction

   // presents one sphere and returns once the request side is no longer stalled
   task automatic offer_sphere(input sphere_row_type sph);
      while (!calm && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_center_x <= sph.cx;
      req_center_y <= sph.cy;
      req_center_z <= sph.cz;
      req_radius   <= sph.radius;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      spheres_sent++;
   endtask

   // holds the request side off until every owed cell has come back
   task automatic settle_cells(input int quiet_cycles);
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) begin
         @(posedge clock);
      end
      repeat (quiet_cycles) @(posedge clock);
   endtask

   task automatic write_cell_shift(input logic [CS_W-1:0] value);
      settle_cells(SETTLE_CYCLES);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cell_shift_now = value;
   endtask

   // result side stalls now and then, except in the calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 6);
      end
   end

   // every cell transaction against the oldest owed cell
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin : check_cell
         cell_hit_type want;
         cells_checked++;
         if (expected_cells.size() == 0) begin
            $error("cell (%0d, %0d, %0d) with none owed", rsp_cell_x, rsp_cell_y,
                   rsp_cell_z);
            errors++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_cell_x !== want.x) begin
               $error("cell_x: expected %0d, got %0d", want.x, rsp_cell_x);
               errors++;
            end
            if (rsp_cell_y !== want.y) begin
               $error("cell_y: expected %0d, got %0d", want.y, rsp_cell_y);
               errors++;
            end
            if (rsp_cell_z !== want.z) begin
               $error("cell_z: expected %0d, got %0d", want.z, rsp_cell_z);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               errors++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped: expected %0d, got %0d", want.clipped, rsp_clipped);
               errors++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      sphere_row_type  sph;
      cell_hit_type    pin_cell;
      logic [CS_W-1:0] shift_pick;
      int              p, n;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_valid      = 1'b0;
      req_center_x   = '0;
      req_center_y   = '0;
      req_center_z   = '0;
      req_radius     = '0;
      rsp_stall      = 1'b0;
      calm           = 1'b0;
      cell_shift_now = CS_W'(CELL_SHIFT_RESET);
      errors         = 0;
      spheres_sent   = 0;
      cells_checked  = 0;
      empty_spheres  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table: pinned rows carry their cell, the rest are enumerated
      for (n = 0; n < N_DIRECTED; n++) begin
         sph = DIRECTED_ROWS[n];
         if (sph.shift != cell_shift_now) begin
            write_cell_shift(sph.shift);
         end
         offer_sphere(sph);
         if (sph.pinned) begin
            pin_cell.x       = sph.px;
            pin_cell.y       = sph.py;
            pin_cell.z       = sph.pz;
            pin_cell.last    = 1'b1;
            pin_cell.clipped = 1'b0;
            expected_cells.insert(expected_cells.size(), pin_cell);
         end else if (overlapped_cells(cell_shift_now, sph.cx, sph.cy, sph.cz,
                                       sph.radius) == 0) begin
            empty_spheres++;
         end
      end

      // random phases, one cell size each; the second runs with no idling
      for (p = 0; p < N_PHASES; p++) begin
         shift_pick = (p == 0) ? CS_W'(2) : (p == 1) ? CS_W'(7)
                                                     : CS_W'($urandom_range(0, 15));
         write_cell_shift(shift_pick);
         calm <= (p == 1);
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // sender holds off once until the unit has drained
            if (p == 2 && n == RANDOM_PER_PHASE / 2) begin
               settle_cells(1);
            end
            sph = random_sphere(cell_shift_now);
            offer_sphere(sph);
            if (overlapped_cells(cell_shift_now, sph.cx, sph.cy, sph.cz,
                                 sph.radius) == 0) begin
               empty_spheres++;
            end
         end
      end

      settle_cells(SETTLE_CYCLES);
      $display("%0d spheres over cell shifts 4 0 10 15 11 2 7 and two random ones",
               spheres_sent);
      $display("%0d cells compared, %0d spheres with no overlapped cell",
               cells_checked, empty_spheres);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* sphere_grid_cell_enumerator_unit.f */
+incdir+sv
sv/sgce_pkg.sv
sv/sgce_ctrl.sv
sv/sgce_datapath.sv
sv/sphere_grid_cell_enumerator_unit.sv
test/testbench.sv
